@@ sv/pmct_pkg.sv @@
// ----------------------------------------------------------------------------
// pmct_pkg
// Types and constants shared by the pointer motion and click tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

	localparam int CURSOR_SIZE = 32;

	localparam logic [12:0] SCREEN_W_RST  = 13'd1024;
	localparam logic [12:0] SCREEN_H_RST  = 13'd768;
	localparam logic [15:0] RES_RST       = 16'd1;
	localparam logic [31:0] TICKS_MS_RST  = 32'd1000000;
	localparam logic [15:0] DCLICK_MS_RST = 16'd500;

	localparam logic [12:0] POS_X_RST = SCREEN_W_RST >> 2;
	localparam logic [12:0] POS_Y_RST = SCREEN_H_RST >> 2;

	localparam int DIV_BITS  = 28;
	localparam int DIV_RADIX = 2;
	localparam int DIV_STEPS = DIV_BITS / DIV_RADIX;
	localparam int DEN_BITS  = 23;
	localparam int QUO_BITS  = 22;
	localparam int SCALE     = 100;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_SCREEN_W  = 3'd0;
	localparam logic [2:0] REG_SCREEN_H  = 3'd1;
	localparam logic [2:0] REG_RES_X     = 3'd2;
	localparam logic [2:0] REG_RES_Y     = 3'd3;
	localparam logic [2:0] REG_TICKS_MS  = 3'd4;
	localparam logic [2:0] REG_DCLICK_MS = 3'd5;

	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_LEFT   = 2'd1;
	localparam logic [1:0] EV_RIGHT  = 2'd2;
	localparam logic [1:0] EV_DOUBLE = 2'd3;

	typedef struct packed {
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic               left_down;
		logic               right_down;
		logic [63:0]        timestamp;
	} sample_t;

	typedef struct packed {
		logic [1:0]  click_event;
		logic [12:0] cursor_x;
		logic [12:0] cursor_y;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLK_MUL,
		ST_CLK_CMP,
		ST_AX_MUL,
		ST_AX_DIV,
		ST_AX_UPD,
		ST_DONE
	} state_t;

endpackage

@@ sv/pointer_motion_and_click_tracker.sv @@
// ----------------------------------------------------------------------------
// pointer_motion_and_click_tracker
// A new sample item is accepted only in idle, once the previous result is loaded.
// One shared 28-bit divider (2 bits/cycle) is run per axis for each item.
// Reset: registers to defaults, buttons released, cursor at a quarter of the screen.
// ----------------------------------------------------------------------------
module pointer_motion_and_click_tracker #(
	parameter int CURSOR_SIZE = pmct_pkg::CURSOR_SIZE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmct_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  pmct_pkg::sample_t             sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output pmct_pkg::result_t             result
);

	logic [12:0] screen_w_q;
	logic [12:0] screen_h_q;
	logic [15:0] res_x_q;
	logic [15:0] res_y_q;
	logic [31:0] ticks_ms_q;
	logic [15:0] dclick_ms_q;

	pmct_pkg::state_t state_q, state_d;

	logic        prev_left_q;
	logic        prev_right_q;
	logic [63:0] last_rel_q;
	logic [12:0] pos_x_q;
	logic [12:0] pos_y_q;
	logic        axis_q;
	logic [$clog2(pmct_pkg::DIV_STEPS)-1:0] cnt_q;
	logic        result_valid_q;

	logic signed [15:0] dx_q;
	logic signed [15:0] dy_q;
	logic        rel_left_q;
	logic        rel_right_q;
	logic [63:0] elapsed_q;
	logic [47:0] prod_q;
	logic [1:0]  ev_q;
	logic        neg_q;
	logic [pmct_pkg::DEN_BITS-1:0] den_q;
	logic [pmct_pkg::DEN_BITS-1:0] rem_q;
	logic [pmct_pkg::DIV_BITS-1:0] quo_q;
	pmct_pkg::result_t result_q;

	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic        accept;
	logic        load_result;

	logic signed [15:0] delta_sel;
	logic [12:0] screen_sel;
	logic [15:0] res_sel;
	logic [15:0] res_eff;
	logic [12:0] pos_sel;
	logic [15:0] delta_mag;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] mul_p;

	logic [pmct_pkg::DEN_BITS-1:0] rem_d;
	logic [pmct_pkg::DIV_BITS-1:0] quo_d;
	logic [pmct_pkg::DEN_BITS:0]   trial;

	logic signed [23:0] rel;
	logic signed [23:0] pos_sum;
	logic signed [14:0] lim_raw;
	logic signed [23:0] lim;
	logic [12:0]        pos_new;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[pmct_pkg::ADDR_W-1:2];
	assign cfg_we  = psel & penable & pwrite;

	always_comb begin
		case (cfg_idx)
			pmct_pkg::REG_SCREEN_W:  prdata = {19'd0, screen_w_q};
			pmct_pkg::REG_SCREEN_H:  prdata = {19'd0, screen_h_q};
			pmct_pkg::REG_RES_X:     prdata = {16'd0, res_x_q};
			pmct_pkg::REG_RES_Y:     prdata = {16'd0, res_y_q};
			pmct_pkg::REG_TICKS_MS:  prdata = ticks_ms_q;
			pmct_pkg::REG_DCLICK_MS: prdata = {16'd0, dclick_ms_q};
			default:                 prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q  <= pmct_pkg::SCREEN_W_RST;
			screen_h_q  <= pmct_pkg::SCREEN_H_RST;
			res_x_q     <= pmct_pkg::RES_RST;
			res_y_q     <= pmct_pkg::RES_RST;
			ticks_ms_q  <= pmct_pkg::TICKS_MS_RST;
			dclick_ms_q <= pmct_pkg::DCLICK_MS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				pmct_pkg::REG_SCREEN_W:  screen_w_q  <= pwdata[12:0];
				pmct_pkg::REG_SCREEN_H:  screen_h_q  <= pwdata[12:0];
				pmct_pkg::REG_RES_X:     res_x_q     <= pwdata[15:0];
				pmct_pkg::REG_RES_Y:     res_y_q     <= pwdata[15:0];
				pmct_pkg::REG_TICKS_MS:  ticks_ms_q  <= pwdata;
				pmct_pkg::REG_DCLICK_MS: dclick_ms_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign sample_stall = (state_q != pmct_pkg::ST_IDLE);
	assign accept       = sample_valid & ~sample_stall;
	assign load_result  = (state_q == pmct_pkg::ST_DONE) & (~result_valid_q | ~result_stall);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pmct_pkg::ST_IDLE:    if (sample_valid) state_d = pmct_pkg::ST_CLK_MUL;
			pmct_pkg::ST_CLK_MUL: state_d = pmct_pkg::ST_CLK_CMP;
			pmct_pkg::ST_CLK_CMP: state_d = pmct_pkg::ST_AX_MUL;
			pmct_pkg::ST_AX_MUL:  state_d = pmct_pkg::ST_AX_DIV;
			pmct_pkg::ST_AX_DIV: begin
				if (cnt_q == ($bits(cnt_q))'(pmct_pkg::DIV_STEPS - 1))
					state_d = pmct_pkg::ST_AX_UPD;
			end
			pmct_pkg::ST_AX_UPD:  state_d = axis_q ? pmct_pkg::ST_DONE : pmct_pkg::ST_AX_MUL;
			pmct_pkg::ST_DONE:    if (load_result) state_d = pmct_pkg::ST_IDLE;
			default:              state_d = pmct_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pmct_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// shared datapath: one multiplier, one divider step pair, one clamp
	always_comb begin
		delta_sel  = axis_q ? dy_q : dx_q;
		screen_sel = axis_q ? screen_h_q : screen_w_q;
		res_sel    = axis_q ? res_y_q : res_x_q;
		pos_sel    = axis_q ? pos_y_q : pos_x_q;
		res_eff    = (res_sel == 16'd0) ? 16'd1 : res_sel;
		delta_mag  = delta_sel[15] ? 16'(~delta_sel + 16'sd1) : 16'(delta_sel);
		if (state_q == pmct_pkg::ST_CLK_MUL) begin
			mul_a = ticks_ms_q;
			mul_b = dclick_ms_q;
		end else begin
			mul_a = {16'd0, delta_mag};
			mul_b = {3'd0, screen_sel};
		end
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		trial = '0;
		for (int i = 0; i < pmct_pkg::DIV_RADIX; i++) begin
			trial = {rem_d, quo_d[pmct_pkg::DIV_BITS-1]};
			quo_d = {quo_d[pmct_pkg::DIV_BITS-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial    = trial - {1'b0, den_q};
				quo_d[0] = 1'b1;
			end
			rem_d = trial[pmct_pkg::DEN_BITS-1:0];
		end
	end

	always_comb begin
		rel     = {2'b00, quo_q[pmct_pkg::QUO_BITS-1:0]};
		if (neg_q)
			rel = -rel;
		pos_sum = 24'(signed'({11'd0, pos_sel})) + rel;
		lim_raw = signed'({2'b00, screen_sel}) - 15'(CURSOR_SIZE);
		lim     = (lim_raw < 0) ? 24'sd0 : 24'(lim_raw);
		if (pos_sum < 0)
			pos_new = 13'd0;
		else if (pos_sum > lim)
			pos_new = lim[12:0];
		else
			pos_new = pos_sum[12:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q    <= 1'b0;
			prev_right_q   <= 1'b0;
			last_rel_q     <= '0;
			pos_x_q        <= pmct_pkg::POS_X_RST;
			pos_y_q        <= pmct_pkg::POS_Y_RST;
			axis_q         <= 1'b0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				prev_left_q  <= sample.left_down;
				prev_right_q <= sample.right_down;
				if (prev_left_q & ~sample.left_down)
					last_rel_q <= sample.timestamp;
				axis_q <= 1'b0;
			end
			if (state_q == pmct_pkg::ST_AX_MUL)
				cnt_q <= '0;
			else if (state_q == pmct_pkg::ST_AX_DIV)
				cnt_q <= cnt_q + 1'b1;
			if (state_q == pmct_pkg::ST_AX_UPD) begin
				if (axis_q)
					pos_y_q <= pos_new;
				else
					pos_x_q <= pos_new;
				axis_q <= 1'b1;
			end
			if (load_result)
				result_valid_q <= 1'b1;
			else if (~result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q        <= sample.delta_x;
			dy_q        <= sample.delta_y;
			rel_left_q  <= prev_left_q & ~sample.left_down;
			rel_right_q <= prev_right_q & ~sample.right_down;
			elapsed_q   <= sample.timestamp - last_rel_q;
		end
		case (state_q)
			pmct_pkg::ST_CLK_MUL: prod_q <= mul_p;
			pmct_pkg::ST_CLK_CMP: begin
				if (rel_left_q)
					ev_q <= (elapsed_q < {16'd0, prod_q}) ? pmct_pkg::EV_DOUBLE
					                                       : pmct_pkg::EV_LEFT;
				else if (rel_right_q)
					ev_q <= pmct_pkg::EV_RIGHT;
				else
					ev_q <= pmct_pkg::EV_NONE;
			end
			pmct_pkg::ST_AX_MUL: begin
				quo_q <= mul_p[pmct_pkg::DIV_BITS-1:0];
				den_q <= pmct_pkg::DEN_BITS'(res_eff * 7'(pmct_pkg::SCALE));
				rem_q <= '0;
				neg_q <= delta_sel[15];
			end
			pmct_pkg::ST_AX_DIV: begin
				quo_q <= quo_d;
				rem_q <= rem_d;
			end
			default: ;
		endcase
		if (load_result) begin
			result_q.click_event <= ev_q;
			result_q.cursor_x    <= pos_x_q;
			result_q.cursor_y    <= pos_y_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == pmct_pkg::ST_CLK_MUL)
		else $error("accepted item did not start the sequencer");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == pmct_pkg::ST_DONE))
		else $error("result appeared outside the done step");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pmct_pkg::ST_AX_DIV |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pmct_pkg::ST_AX_DIV |-> sample_stall)
		else $error("sample taken while divider busy");
`endif

endmodule

@@ tb/pointer_motion_and_click_tracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_motion_and_click_tracker_tb
// Drives pointer samples with random button activity, motion and timestamps
// through several register settings. A scoreboard predicts each click event
// and cursor position and compares every result with it in order.
// ----------------------------------------------------------------------------
module pointer_motion_and_click_tracker_tb;

	class pointer_scoreboard;
		logic [12:0] screen_w, screen_h;
		logic [15:0] res_x, res_y;
		logic [31:0] ticks_per_ms;
		logic [15:0] dclick_ms;
		bit          prev_left, prev_right;
		logic [63:0] last_release;
		logic [12:0] pos_x, pos_y;
		pmct_pkg::result_t queued_reports[$];
		int          errors;
		int          samples;
		int          tally[4];

		function new();
			screen_w     = 13'd1024;
			screen_h     = 13'd768;
			res_x        = 16'd1;
			res_y        = 16'd1;
			ticks_per_ms = 32'd1000000;
			dclick_ms    = 16'd500;
			prev_left    = 1'b0;
			prev_right   = 1'b0;
			last_release = '0;
			pos_x        = 13'd256;
			pos_y        = 13'd192;
			errors       = 0;
			samples      = 0;
			tally        = '{0, 0, 0, 0};
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] value);
			case (idx)
				pmct_pkg::REG_SCREEN_W:  screen_w = value[12:0];
				pmct_pkg::REG_SCREEN_H:  screen_h = value[12:0];
				pmct_pkg::REG_RES_X:     res_x = value[15:0];
				pmct_pkg::REG_RES_Y:     res_y = value[15:0];
				pmct_pkg::REG_TICKS_MS:  ticks_per_ms = value;
				pmct_pkg::REG_DCLICK_MS: dclick_ms = value[15:0];
				default: ;
			endcase
		endfunction

		function logic [12:0] slide_axis(logic [12:0] pos, logic [12:0] scr,
				logic [15:0] res, logic signed [15:0] d);
			longint ls, ld, div, rel, p, lim;
			ls  = scr;
			ld  = d;
			div = (res == 16'd0) ? 1 : longint'(res);
			rel = ls * ld / div / 100;
			p   = longint'(pos) + rel;
			lim = ls - pmct_pkg::CURSOR_SIZE;
			if (lim < 0) lim = 0;
			if (p < 0) p = 0;
			if (p > lim) p = lim;
			return 13'(p);
		endfunction

		function void take_sample(pmct_pkg::sample_t s);
			pmct_pkg::result_t r;
			logic [63:0] elapsed, ms;
			r.click_event = pmct_pkg::EV_NONE;
			if (prev_left && !s.left_down) begin
				elapsed = s.timestamp - last_release;
				ms = (ticks_per_ms == 32'd0) ? '1 : elapsed / ticks_per_ms;
				r.click_event = (ms < dclick_ms) ? pmct_pkg::EV_DOUBLE : pmct_pkg::EV_LEFT;
				last_release = s.timestamp;
			end else if (prev_right && !s.right_down) begin
				r.click_event = pmct_pkg::EV_RIGHT;
			end
			prev_left  = s.left_down;
			prev_right = s.right_down;
			pos_x = slide_axis(pos_x, screen_w, res_x, s.delta_x);
			pos_y = slide_axis(pos_y, screen_h, res_y, s.delta_y);
			r.cursor_x = pos_x;
			r.cursor_y = pos_y;
			queued_reports.push_back(r);
			samples++;
			tally[r.click_event]++;
		endfunction

		function void check_report(pmct_pkg::result_t got);
			pmct_pkg::result_t want;
			if (queued_reports.size() == 0) begin
				$display("%0t: unexpected result event %0d x %0d y %0d", $time,
					got.click_event, got.cursor_x, got.cursor_y);
				errors++;
			end else begin
				want = queued_reports.pop_front();
				if (got.click_event !== want.click_event) begin
					$display("%0t: click_event expected %0d actual %0d", $time,
						want.click_event, got.click_event);
					errors++;
				end
				if (got.cursor_x !== want.cursor_x) begin
					$display("%0t: cursor_x expected %0d actual %0d", $time,
						want.cursor_x, got.cursor_x);
					errors++;
				end
				if (got.cursor_y !== want.cursor_y) begin
					$display("%0t: cursor_y expected %0d actual %0d", $time,
						want.cursor_y, got.cursor_y);
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return queued_reports.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [pmct_pkg::ADDR_W-1:0] paddr;
	logic [31:0]       pwdata, prdata;
	logic              sample_valid, sample_stall;
	pmct_pkg::sample_t sample;
	logic              result_valid, result_stall;
	pmct_pkg::result_t result;

	pointer_scoreboard sb = new();
	int unsigned tx_gap, rx_gap;
	int          settings;
	bit          held_left, held_right;
	logic [63:0] clock_now;

	pointer_motion_and_click_tracker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	task automatic write_register(logic [2:0] idx, logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apply_settings(logic [31:0] w, logic [31:0] h, logic [31:0] rx,
			logic [31:0] ry, logic [31:0] t, logic [31:0] d);
		write_register(pmct_pkg::REG_SCREEN_W, w);
		write_register(pmct_pkg::REG_SCREEN_H, h);
		write_register(pmct_pkg::REG_RES_X, rx);
		write_register(pmct_pkg::REG_RES_Y, ry);
		write_register(pmct_pkg::REG_TICKS_MS, t);
		write_register(pmct_pkg::REG_DCLICK_MS, d);
		settings++;
	endtask

	task automatic send_sample(pmct_pkg::sample_t s);
		int unsigned hold;
		hold = $urandom_range(0, tx_gap);
		if (hold != 0) begin
			sample_valid = 1'b0;
			repeat (hold) @(negedge clk);
		end
		sample_valid = 1'b1;
		sample       = s;
		do @(posedge clk); while (sample_stall);
		sb.take_sample(s);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (sb.outstanding() != 0) @(negedge clk);
	endtask

	function automatic pmct_pkg::sample_t mk(int dx, int dy, bit l, bit r, logic [63:0] ts);
		pmct_pkg::sample_t s;
		s.delta_x    = 16'(dx);
		s.delta_y    = 16'(dy);
		s.left_down  = l;
		s.right_down = r;
		s.timestamp  = ts;
		return s;
	endfunction

	function automatic logic [15:0] pick_delta();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom_range(0, 400) - 200);
		endcase
	endfunction

	function automatic logic [31:0] pick_screen();
		case ($urandom_range(0, 5))
			0: return 32'd8191;
			1: return 32'd64;
			2: return $urandom_range(0, 8191);
			default: return $urandom_range(64, 8191);
		endcase
	endfunction

	function automatic logic [31:0] pick_res();
		return $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 300);
	endfunction

	function automatic pmct_pkg::sample_t next_sample();
		pmct_pkg::sample_t s;
		logic [63:0] window, step;
		if ($urandom_range(0, 9) == 0) begin
			held_left  = 1'($urandom_range(0, 1));
			held_right = 1'($urandom_range(0, 1));
			clock_now  = {$urandom, $urandom};
		end else begin
			if ($urandom_range(0, 2) == 0) held_left = !held_left;
			if ($urandom_range(0, 3) == 0) held_right = !held_right;
			window = sb.ticks_per_ms * sb.dclick_ms;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: step = window * $urandom_range(0, 99) / 400;
				4, 5, 6, 7: step = window + window * $urandom_range(0, 99) / 100;
				8: step = window - $urandom_range(0, 1);
				default: step = {$urandom, $urandom};
			endcase
			if (window == 0) step = $urandom_range(0, 5000);
			clock_now += step;
		end
		s.delta_x    = pick_delta();
		s.delta_y    = pick_delta();
		s.left_down  = held_left;
		s.right_down = held_right;
		s.timestamp  = clock_now;
		return s;
	endfunction

	initial begin
		pmct_pkg::sample_t opening[$];
		int      phase, n;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		sample_valid = 1'b0;
		sample       = '0;
		result_stall = 1'b0;
		settings     = 1;
		held_left    = 1'b0;
		held_right   = 1'b0;
		clock_now    = '0;
		opening = '{
			mk(32767, -32768, 0, 0, 64'd0),
			mk(-32768, 32767, 0, 0, 64'd10),
			mk(1, -1, 1, 0, 64'd20),
			mk(-1, 1, 0, 0, 64'd120),
			mk(5, -5, 1, 0, 64'd200),
			mk(0, 0, 0, 0, 64'd500000119),
			mk(-5, 5, 1, 0, 64'd500000200),
			mk(0, 0, 0, 0, 64'd1000000119),
			mk(99, -99, 0, 1, 64'd1000000200),
			mk(-99, 99, 0, 0, 64'd1000000300),
			mk(100, -100, 1, 1, 64'd1000000400),
			mk(-100, 100, 0, 0, 64'd1000000500),
			mk(0, 0, 1, 1, 64'hFFFF_FFFF_FFFF_FFF0),
			mk(0, 0, 0, 1, 64'hFFFF_FFFF_FFFF_FFF8),
			mk(0, 0, 1, 0, 64'hFFFF_FFFF_FFFF_FFFC),
			mk(0, 0, 0, 0, 64'd3),
			mk(-32768, -32768, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF),
			mk(32767, 32767, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF),
			mk(0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF)
		};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (phase = 0; phase < 10; phase++) begin
			tx_gap = (phase % 3 == 1) ? 0 : 17;
			rx_gap = (phase % 4 == 2) ? 0 : 17;
			case (phase)
				0: ;
				1: apply_settings(8191, 8191, 65535, 65535, 32'hFFFF_FFFF, 65535);
				2: apply_settings(64, 64, 0, 0, 0, 0);
				3: apply_settings(16, 31, 1, 1, 1, 1000);
				4: apply_settings(32, 8000, 7, 3, 1000, 250);
				default: apply_settings(pick_screen(), pick_screen(), pick_res(), pick_res(),
					$urandom_range(0, 1) ? $urandom : $urandom_range(1, 100000),
					$urandom_range(0, 65535));
			endcase
			if (phase == 0) foreach (opening[i]) send_sample(opening[i]);
			clock_now = {$urandom, $urandom};
			for (n = 0; n < 70; n++) begin
				if (phase == 4 && n == 35) begin
					sample_valid = 1'b0;
					wait_idle();
				end
				send_sample(next_sample());
			end
			sample_valid = 1'b0;
			wait_idle();
		end

		repeat (50) @(negedge clk);
		if (sb.outstanding() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.outstanding());
			sb.errors++;
		end
		$display("Ran %0d samples under %0d register settings.", sb.samples, settings);
		$display("Events seen: %0d none, %0d left, %0d right, %0d double.",
			sb.tally[pmct_pkg::EV_NONE], sb.tally[pmct_pkg::EV_LEFT],
			sb.tally[pmct_pkg::EV_RIGHT], sb.tally[pmct_pkg::EV_DOUBLE]);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		int unsigned hold;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = $urandom_range(0, rx_gap);
			if (hold != 0) begin
				result_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			sb.check_report(result);
			@(negedge clk);
		end
	end

	initial begin
		#4ms;
		$display("%0t: run timed out", $time);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
